>>> hw/rtl/kdlpr_pkg.sv
// Package: sizes, register indexes, action codes and lane event/config types.
`default_nettype none
package kdlpr_pkg;
  localparam int unsigned ROWS    = 7;
  localparam int unsigned COLS    = 3;
  localparam int unsigned NSLOTS  = ROWS * COLS;
  localparam int unsigned BMW     = 21;
  localparam int unsigned SLOTW   = 5;
  localparam int unsigned ADDRW   = 5;

  localparam logic [BMW-1:0] SLOT_MASK = BMW'((64'd1 << NSLOTS) - 64'd1);

  typedef enum logic [1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_LONG    = 2'd2,
    ACT_REPEAT  = 2'd3
  } action_e;

  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_LONG     = 3'd1;
  localparam logic [2:0] REG_DELAY    = 3'd2;
  localparam logic [2:0] REG_PERIOD   = 3'd3;
  localparam logic [2:0] REG_MASK     = 3'd4;

  // what one lane reports for its slot in the current scan
  typedef struct packed {
    logic ev_press;
    logic ev_release;
    logic ev_long;
    logic ev_repeat;
  } lane_ev_t;

  typedef struct packed {
    logic [15:0] hold_ms;
    logic [15:0] first_rep_ms;
    logic [15:0] repeat_period_ms;
  } lane_cfg_t;
endpackage
`default_nettype wire

>>> hw/rtl/kdlpr_if.sv
// Valid/ready stream interfaces for scans and events.
`default_nettype none
interface kdlpr_scan_if;
  logic        valid;
  logic        ready;
  logic [20:0] pressed_bits;
  logic [15:0] elapsed_ms;
  logic        scan_ok;
  modport source (output valid, pressed_bits, elapsed_ms, scan_ok, input ready);
  modport sink (input valid, pressed_bits, elapsed_ms, scan_ok, output ready);
endinterface

interface kdlpr_event_if;
  logic       valid;
  logic       ready;
  logic [4:0] slot;
  logic [1:0] action;
  logic       last;
  modport source (output valid, slot, action, last, input ready);
  modport sink (input valid, slot, action, last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/keypad_debounce_long_press_repeat_top.sv
// Top level: scan debounce, per-slot lanes, event merge and APB registers.
`default_nettype none
// Keypad debouncer with long-press and auto-repeat events.
// scan_i takes one matrix scan per transfer (bitmap, elapsed ms, scan_ok).
// evt_o gives one event transfer per key event: slot, action, last.
// Flow: the scan is registered; in the next cycle all 21 lanes evaluate in
// parallel and their events are latched into the merge stage.
// The merge stage then hands out one event per cycle while the receiver is
// ready, in slot order, long press before repeat within a slot; the last
// event of a scan has last set. A scan can yield up to 42 events. A failed
// scan only moves the clock, with no lane evaluation and no events.
// scan_i.ready is low while a scan is in flight or events are pending.
// If the receiver stalls, the current event holds and no new scan is taken.
// Reset clears the clock, debounce state, stable bitmap and registers to
// their defaults; per-slot times are written at each press, so no clearing
// pass is needed. Users must write configuration over APB while idle; unchecked.
module keypad_debounce_long_press_repeat_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  kdlpr_scan_if.sink   scan_i,
  kdlpr_event_if.source evt_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [kdlpr_pkg::ADDRW-1:0] paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // configuration
  logic [2:0]  dbc_q;
  logic [15:0] long_q, delay_q, period_q;
  logic [20:0] mask_q;
  logic        wr;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbc_q    <= 3'd2;
      long_q   <= 16'd800;
      delay_q  <= 16'd500;
      period_q <= 16'd150;
      mask_q   <= 21'd170;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (ridx)
        kdlpr_pkg::REG_DEBOUNCE: dbc_q    <= pwdata[2:0];
        kdlpr_pkg::REG_LONG:     long_q   <= pwdata[15:0];
        kdlpr_pkg::REG_DELAY:    delay_q  <= pwdata[15:0];
        kdlpr_pkg::REG_PERIOD:   period_q <= pwdata[15:0];
        kdlpr_pkg::REG_MASK:     mask_q   <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      kdlpr_pkg::REG_DEBOUNCE: prdata = {29'd0, dbc_q};
      kdlpr_pkg::REG_LONG:     prdata = {16'd0, long_q};
      kdlpr_pkg::REG_DELAY:    prdata = {16'd0, delay_q};
      kdlpr_pkg::REG_PERIOD:   prdata = {16'd0, period_q};
      kdlpr_pkg::REG_MASK:     prdata = {11'd0, mask_q};
      default:                 prdata = '0;
    endcase
  end

  // scan front end: clock updates on every transfer, debounce only when scan_ok
  logic [31:0] now_q;
  logic [20:0] last_q, stable_q, prev_q;
  logic [2:0]  agree_q, agree_d, thr;
  logic        eval_q, merge_busy;
  logic        take;
  logic [20:0] raw;

  assign scan_i.ready = !eval_q && !merge_busy;
  assign take = scan_i.valid && scan_i.ready;
  assign raw  = scan_i.pressed_bits & kdlpr_pkg::SLOT_MASK;
  assign thr  = (dbc_q == 3'd0) ? 3'd1 : dbc_q;

  always_comb begin
    if (raw == last_q) agree_d = (agree_q < thr) ? agree_q + 3'd1 : thr;
    else agree_d = 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0; last_q <= '0; stable_q <= '0; prev_q <= '0;
      agree_q <= '0; eval_q <= 1'b0;
    end else begin
      eval_q <= 1'b0;
      if (take) begin
        now_q <= now_q + {16'd0, scan_i.elapsed_ms};
        if (scan_i.scan_ok) begin
          agree_q <= agree_d;
          last_q  <= raw;
          prev_q  <= stable_q;
          if (agree_d >= thr) stable_q <= raw;
          eval_q  <= 1'b1;
        end
      end
    end
  end

  // lanes
  kdlpr_pkg::lane_cfg_t lcfg;
  kdlpr_pkg::lane_ev_t  lev [kdlpr_pkg::NSLOTS];
  assign lcfg = '{hold_ms: long_q, first_rep_ms: delay_q,
                  repeat_period_ms: period_q};

  for (genvar s = 0; s < kdlpr_pkg::NSLOTS; s++) begin : g_lane
    kdlpr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .upd_i    (eval_q),
      .down_i   (stable_q[s]),
      .was_i    (prev_q[s]),
      .rep_en_i (mask_q[s]),
      .now_i    (now_q),
      .cfg_i    (lcfg),
      .ev_o     (lev[s])
    );
  end

  kdlpr_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (eval_q),
    .ev_i   (lev),
    .busy_o (merge_busy),
    .ev_o   (evt_o)
  );

  // no new scan while events of the previous one are pending
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_busy |-> !take) else $error("scan taken while events pending");
  // a stalled event holds its slot and action
  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid && !evt_o.ready |=> evt_o.valid && $stable(evt_o.slot)
    && $stable(evt_o.action)) else $error("event changed under stall");
  // an evaluation cycle follows only a valid scan transfer
  a_eval_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_q |-> $past(take)) else $error("lane update without scan");
endmodule
`default_nettype wire

>>> hw/rtl/kdlpr_lane.sv
// One per-slot lane: press time, repeat time and long-press flag.
`default_nettype none
module kdlpr_lane (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        upd_i,
  input  wire                        down_i,
  input  wire                        was_i,
  input  wire                        rep_en_i,
  input  wire  [31:0]                now_i,
  input  wire  kdlpr_pkg::lane_cfg_t cfg_i,
  output kdlpr_pkg::lane_ev_t        ev_o
);
  logic [31:0] press_q, nrep_q;
  logic        lsent_q;
  logic [31:0] held, rdiff;
  logic        lhit, rhit;

  assign held  = now_i - press_q;
  assign rdiff = now_i - nrep_q;
  assign lhit  = !lsent_q && (held >= {16'd0, cfg_i.hold_ms});
  assign rhit  = rep_en_i && !rdiff[31];

  always_comb begin
    ev_o = '0;
    if (down_i && !was_i) ev_o.ev_press = 1'b1;
    else if (!down_i && was_i) ev_o.ev_release = 1'b1;
    else if (down_i) begin
      ev_o.ev_long   = lhit;
      ev_o.ev_repeat = rhit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsent_q <= 1'b0;
    end else if (upd_i) begin
      if (ev_o.ev_press) lsent_q <= 1'b0;
      else if (ev_o.ev_long) lsent_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      if (ev_o.ev_press) begin
        press_q <= now_i;
        nrep_q  <= now_i + {16'd0, cfg_i.first_rep_ms};
      end else if (ev_o.ev_repeat) begin
        nrep_q  <= now_i + {16'd0, cfg_i.repeat_period_ms};
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/kdlpr_merge.sv
// Merge stage: walks the latched lane events in slot order, one per cycle while ev_o.ready.
`default_nettype none
module kdlpr_merge (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  wire kdlpr_pkg::lane_ev_t ev_i [kdlpr_pkg::NSLOTS],
  output logic                 busy_o,
  kdlpr_event_if.source        ev_o
);
  localparam int unsigned NB = 2 * kdlpr_pkg::NSLOTS;
  // pending bits: slot s owns bit 2s (press/release/long) and 2s+1 (repeat)
  logic [NB-1:0] pend_q, pend_d;
  logic [1:0]    act_q [kdlpr_pkg::NSLOTS];
  logic [NB-1:0] low_bit, rest;
  logic [$clog2(NB)-1:0] pos;

  always_comb begin
    pos = '0;
    for (int i = NB - 1; i >= 0; i--) if (pend_q[i]) pos = ($clog2(NB))'(i);
  end
  assign low_bit = pend_q & (~pend_q + NB'(1));
  assign rest    = pend_q & ~low_bit;

  assign busy_o   = |pend_q;
  assign ev_o.valid  = |pend_q;
  assign ev_o.slot   = kdlpr_pkg::SLOTW'(pos >> 1);
  assign ev_o.action = pos[0] ? kdlpr_pkg::ACT_REPEAT : act_q[pos[$clog2(NB)-1:1]];
  assign ev_o.last   = (rest == '0);

  always_comb begin
    pend_d = pend_q;
    if (load_i) begin
      for (int s = 0; s < kdlpr_pkg::NSLOTS; s++) begin
        pend_d[2*s]   = ev_i[s].ev_press | ev_i[s].ev_release | ev_i[s].ev_long;
        pend_d[2*s+1] = ev_i[s].ev_repeat;
      end
    end else if (ev_o.valid && ev_o.ready) begin
      pend_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else pend_q <= pend_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int s = 0; s < kdlpr_pkg::NSLOTS; s++) begin
        act_q[s] <= ev_i[s].ev_press   ? kdlpr_pkg::ACT_PRESS :
                    ev_i[s].ev_release ? kdlpr_pkg::ACT_RELEASE : kdlpr_pkg::ACT_LONG;
      end
    end
  end
endmodule
`default_nettype wire
